// ===== hdl/shbd_pkg.sv =====
// ----------------------------------------------------------------------------
// shbd_pkg
// Shared types, constants and the CRC byte update for the sync hunt deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package shbd_pkg;

    localparam int unsigned ADDR_W = 3;

    localparam logic [31:0] SYNC_RESET = 32'h3915_ED30;
    localparam logic [12:0] LEN_RESET  = 13'd514;
    localparam logic [12:0] LEN_MAX    = 13'd4096;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    // register index, taken from paddr[2]
    localparam logic REG_SYNC_WORD    = 1'b0;
    localparam logic REG_FRAME_LENGTH = 1'b1;

    typedef struct packed {
        logic [31:0] sync_word;
        logic [12:0] frame_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [11:0] byte_index;
        logic        last_of_frame;
        logic        crc_good;
    } t_result;

    // CCITT CRC, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/shbd_cfg.sv =====
// ----------------------------------------------------------------------------
// shbd_cfg
// APB register file: sync word and frame length.
// ----------------------------------------------------------------------------
`default_nettype none

module shbd_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [shbd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output shbd_pkg::t_cfg                  o_cfg
);
    import shbd_pkg::*;

    t_cfg r_cfg;
    logic wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_word    <= SYNC_RESET;
            r_cfg.frame_length <= LEN_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_SYNC_WORD:    r_cfg.sync_word    <= pwdata;
                REG_FRAME_LENGTH: r_cfg.frame_length <= pwdata[12:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SYNC_WORD:    prdata = r_cfg.sync_word;
            REG_FRAME_LENGTH: prdata = {19'd0, r_cfg.frame_length};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/shbd_core.sv =====
// ----------------------------------------------------------------------------
// shbd_core
// Sync hunt, byte packing, frame count, CRC check; one bit per accepted cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module shbd_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic            i_data_bit,
    input  wire shbd_pkg::t_cfg  i_cfg,
    output logic                 o_res_valid,
    output shbd_pkg::t_result    o_res
);
    import shbd_pkg::*;

    logic        r_hunting,    n_hunting;
    logic [31:0] r_sync_shift, n_sync_shift;
    logic [7:0]  r_byte_shift, n_byte_shift;
    logic [2:0]  r_bit_count,  n_bit_count;
    logic [11:0] r_byte_count, n_byte_count;
    logic [15:0] r_crc,        n_crc;

    logic [31:0] sync_cand;
    logic [7:0]  byte_cand;
    logic [2:0]  bit_cand;
    logic [15:0] crc_cand;
    logic [12:0] limit;
    logic [12:0] next_count;
    logic        last;

    assign sync_cand  = {r_sync_shift[30:0], i_data_bit};
    assign byte_cand  = {r_byte_shift[6:0], i_data_bit};
    assign bit_cand   = r_bit_count + 3'd1;
    assign crc_cand   = crc_byte(r_crc, byte_cand);
    assign limit      = (i_cfg.frame_length > LEN_MAX) ? LEN_MAX : i_cfg.frame_length;
    assign next_count = {1'b0, r_byte_count} + 13'd1;
    assign last       = (next_count >= limit);

    always_comb begin
        n_hunting    = r_hunting;
        n_sync_shift = r_sync_shift;
        n_byte_shift = r_byte_shift;
        n_bit_count  = r_bit_count;
        n_byte_count = r_byte_count;
        n_crc        = r_crc;
        o_res_valid  = 1'b0;
        o_res.data_byte     = byte_cand;
        o_res.byte_index    = r_byte_count;
        o_res.last_of_frame = last;
        o_res.crc_good      = last && (crc_cand == 16'd0);
        if (i_accept) begin
            if (r_hunting) begin
                n_sync_shift = sync_cand;
                if (sync_cand == i_cfg.sync_word) begin
                    n_hunting    = 1'b0;
                    n_bit_count  = 3'd0;
                    n_byte_count = 12'd0;
                    n_crc        = CRC_INIT;
                end
            end else begin
                n_byte_shift = byte_cand;
                n_bit_count  = bit_cand;
                if (bit_cand == 3'd0) begin
                    o_res_valid  = 1'b1;
                    n_crc        = crc_cand;
                    n_byte_count = next_count[11:0];
                    if (last) begin
                        n_hunting = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hunting    <= 1'b1;
            r_sync_shift <= 32'd0;
            r_byte_shift <= 8'd0;
            r_bit_count  <= 3'd0;
            r_byte_count <= 12'd0;
            r_crc        <= CRC_INIT;
        end else begin
            r_hunting    <= n_hunting;
            r_sync_shift <= n_sync_shift;
            r_byte_shift <= n_byte_shift;
            r_bit_count  <= n_bit_count;
            r_byte_count <= n_byte_count;
            r_crc        <= n_crc;
        end
    end

    a_no_byte_while_hunting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hunting |-> !o_res_valid)
        else $error("byte emitted while hunting");

    a_byte_on_eighth_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_bit_count == 3'd7))
        else $error("byte emitted off the byte boundary");

    a_last_returns_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last_of_frame) |=> r_hunting)
        else $error("frame end did not restart the hunt");

    a_good_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.crc_good) |-> o_res.last_of_frame)
        else $error("crc verdict on a byte that is not last");

endmodule

`default_nettype wire

// ===== hdl/shbd_skid.sv =====
// ----------------------------------------------------------------------------
// shbd_skid
// Output register with one skid entry between the core and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module shbd_skid (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_res_valid,
    input  wire shbd_pkg::t_result i_res,
    output logic                   o_full,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output shbd_pkg::t_result      o_out
);
    import shbd_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_res_valid;
            end
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_no_result_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_res_valid)
        else $error("result arrived while both slots were full");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry did not move to the output register");

endmodule

`default_nettype wire

// ===== hdl/sync_hunt_block_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// sync_hunt_block_deframer_unit
// Serial sync word hunter and block deframer with CRC-16/CCITT check.
// ----------------------------------------------------------------------------
// Takes one received bit per cycle while the input is not stalled: each bit
// goes through a single pass of hunt, byte packing and CRC logic between the
// state registers and a two-entry output register (output register plus one
// skid entry). While hunting, bits shift MSB first into a 32-bit register that
// is compared with sync_word; a match starts a frame. Frame bits pack MSB first
// into bytes, and each byte leaves as one request with its index in the frame.
// The byte that reaches frame_length (capped at 4096) carries last_of_frame and
// the CRC verdict: CCITT 0x1021, init 0xFFFF, run over all frame bytes including
// the two CRC bytes; crc_good is 1 when the residue is zero. The hunt register
// keeps its contents across frames. Input stalls only while both output slots
// are full, so a downstream that takes each request before the next byte is
// done never stalls the bit stream. Registers sync_word (addr 0) and frame_length
// (addr 4) sit on the APB port; write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_hunt_block_deframer_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // bit input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_data_bit,
    // byte output channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [7:0]                       o_data_byte,
    output logic [11:0]                      o_byte_index,
    output logic                             o_last_of_frame,
    output logic                             o_crc_good,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [shbd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import shbd_pkg::*;

    t_cfg    cfg;
    t_result res;
    t_result out;
    logic    res_valid;
    logic    full;
    logic    accept;

    // take a bit whenever the skid entry is free
    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    shbd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    shbd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_bit  (i_data_bit),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    shbd_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_full      (full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (out)
    );

    assign o_data_byte     = out.data_byte;
    assign o_byte_index    = out.byte_index;
    assign o_last_of_frame = out.last_of_frame;
    assign o_crc_good      = out.crc_good;

endmodule

`default_nettype wire

// ===== verif/sync_hunt_block_deframer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_hunt_block_deframer_unit_tb
// Self-checking bench for the sync hunt deframer. A table of directed bit
// segments and register writes runs first, then random frames, broken sync
// words and noise. A bit-level model in the bench predicts every byte request
// and each request leaving the block is compared against it field by field.
// ----------------------------------------------------------------------------
module sync_hunt_block_deframer_unit_tb;
    import shbd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 5_000_000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned LONG_HOLD    = 300;

    typedef enum logic {ROW_WRITE, ROW_BITS} t_row_kind;

    // one line of the directed plan: a register write or a run of bit segments
    typedef struct {
        t_row_kind   kind;
        logic        reg_idx;
        logic [31:0] value;
        int          nbits;
        int          reps;
        bit          typed;
        t_result     res;
    } t_stim_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    logic                i_data_bit  = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [7:0]          o_data_byte;
    logic [11:0]         o_byte_index;
    logic                o_last_of_frame;
    logic                o_crc_good;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ADDR_W-1:0]   paddr       = '0;
    logic [31:0]         pwdata      = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Typed expectation that rides along with each bit. When set on the bit
    // that completes a byte, it replaces the predicted byte request.
    logic                typed_on    = 1'b0;
    t_result             typed_res   = '0;

    // Deframer model state and its copy of the registers
    logic [31:0]         cfg_sync    = SYNC_RESET;
    logic [12:0]         cfg_len     = LEN_RESET;
    bit                  hunt_on     = 1'b1;
    logic [31:0]         hunt_reg    = '0;
    logic [7:0]          pack_reg    = '0;
    logic [2:0]          pack_cnt    = '0;
    logic [11:0]         byte_num    = '0;
    logic [15:0]         crc_acc     = CRC_INIT;

    // Bytes predicted but not yet seen on the output
    t_result             byte_q[$];

    int                  errors_seen  = 0;
    int                  results_seen = 0;
    int                  bits_sent    = 0;
    longint              cycles       = 0;
    bit                  calm         = 1'b0;
    int                  hold_asks    = 0;
    int                  hold_seen    = 0;
    int                  hold_left    = 0;
    int                  wait_left    = 0;

    sync_hunt_block_deframer_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_bit      (i_data_bit),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_data_byte     (o_data_byte),
        .o_byte_index    (o_byte_index),
        .o_last_of_frame (o_last_of_frame),
        .o_crc_good      (o_crc_good),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    // CCITT CRC, serial form: feed the byte in one bit at a time, MSB first
    function automatic logic [15:0] crc_shift_in(input logic [15:0] crc, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return crc;
    endfunction

    // Idle draw shared by both sides: mostly none, sometimes a random wait
    function automatic int draw_wait();
        if (calm || $urandom_range(0, 2) != 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    function automatic t_stim_row mk_row(input t_row_kind kind, input logic reg_idx,
                                         input logic [31:0] value, input int nbits,
                                         input int reps, input bit typed, input t_result res);
        t_stim_row r;
        r.kind    = kind;
        r.reg_idx = reg_idx;
        r.value   = value;
        r.nbits   = nbits;
        r.reps    = reps;
        r.typed   = typed;
        r.res     = res;
        return r;
    endfunction

    // Advance the deframer model by one accepted bit and queue the byte it
    // completes, if any.
    task automatic absorb_bit(input logic b, input logic tag, input t_result tag_res);
        t_result r;
        int      limit;
        int      next_num;
        bit      made;
        made = 1'b0;
        r    = '0;
        if (hunt_on) begin
            // the hunt register only moves while hunting and is never cleared
            hunt_reg = {hunt_reg[30:0], b};
            if (hunt_reg == cfg_sync) begin
                pack_cnt = '0;
                byte_num = '0;
                crc_acc  = CRC_INIT;
                hunt_on  = 1'b0;
            end
        end else begin
            pack_reg = {pack_reg[6:0], b};
            pack_cnt = pack_cnt + 3'd1;
            if (pack_cnt == 3'd0) begin
                crc_acc  = crc_shift_in(crc_acc, pack_reg);
                // lengths above the cap count as the cap; 0 and 1 end at once
                limit    = (cfg_len > LEN_MAX) ? int'(LEN_MAX) : int'(cfg_len);
                next_num = int'(byte_num) + 1;
                r.data_byte  = pack_reg;
                r.byte_index = byte_num;
                if (next_num >= limit) begin
                    r.last_of_frame = 1'b1;
                    r.crc_good      = (crc_acc == 16'h0000);
                    hunt_on         = 1'b1;
                end
                byte_num = next_num[11:0];
                made     = 1'b1;
            end
        end
        if (tag)
            byte_q.push_back(tag_res);
        else if (made)
            byte_q.push_back(r);
    endtask

    // Input monitor: every accepted bit goes through the model
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            absorb_bit(i_data_bit, typed_on, typed_res);
    end

    // Output checker: compare each accepted byte request with the oldest prediction
    always @(posedge i_clk) begin : byte_check
        t_result want;
        if (o_out_valid && !i_out_stall) begin
            results_seen++;
            if (byte_q.size() == 0) begin
                $error("unexpected byte %0h at index %0d", o_data_byte, o_byte_index);
                errors_seen++;
            end else begin
                want = byte_q.pop_front();
                if (o_data_byte !== want.data_byte) begin
                    $error("data_byte expected %0h got %0h", want.data_byte, o_data_byte);
                    errors_seen++;
                end
                if (o_byte_index !== want.byte_index) begin
                    $error("byte_index expected %0d got %0d", want.byte_index, o_byte_index);
                    errors_seen++;
                end
                if (o_last_of_frame !== want.last_of_frame) begin
                    $error("last_of_frame expected %0b got %0b",
                           want.last_of_frame, o_last_of_frame);
                    errors_seen++;
                end
                if (o_crc_good !== want.crc_good) begin
                    $error("crc_good expected %0b got %0b", want.crc_good, o_crc_good);
                    errors_seen++;
                end
            end
        end
    end

    // Output sink: draw a stall after every accepted request; a long hold,
    // asked for by the stimulus, overrides it and is counted down here.
    always @(posedge i_clk) begin : byte_sink
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
        end
        if (o_out_valid && !i_out_stall)
            wait_left = draw_wait();
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (wait_left > 0) begin
            wait_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("sync_hunt_block_deframer_unit_tb: FAIL");
            $finish;
        end
    end

    // Offer one bit, hold it until accepted, then draw the gap before the next.
    // With no gap, valid stays high and the next call just swaps the data.
    task automatic send_bit(input logic b, input logic tag, input t_result tag_res);
        int gap;
        i_in_valid <= 1'b1;
        i_data_bit <= b;
        typed_on   <= tag;
        typed_res  <= tag_res;
        do @(posedge i_clk); while (o_in_stall);
        bits_sent++;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Send the low nbits of value, MSB first; a tag goes on the final bit only
    task automatic send_bits(input logic [31:0] value, input int nbits,
                             input logic tag, input t_result tag_res);
        for (int i = nbits - 1; i >= 0; i--)
            send_bit(value[i], tag && (i == 0), tag_res);
    endtask

    // Drop valid, wait for every predicted byte, then let the pipe settle
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (byte_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup phase, then access phase until pready, then idle
    task automatic apb_write(input logic reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_SYNC_WORD)
            cfg_sync = value;
        else
            cfg_len = value[12:0];
        @(posedge i_clk);
    endtask

    // Sync word plus one frame of random bytes at the current length; with
    // crc_fix the last two bytes carry the CRC so the residue comes out zero.
    task automatic send_frame(input bit crc_fix);
        logic [7:0]  body[$];
        logic [15:0] c;
        int          n;
        n = (cfg_len > LEN_MAX) ? int'(LEN_MAX) : int'(cfg_len);
        if (n < 1)
            n = 1;
        for (int k = 0; k < n; k++)
            body.push_back(8'($urandom_range(0, 255)));
        if (crc_fix && n >= 2) begin
            c = CRC_INIT;
            for (int k = 0; k < n - 2; k++)
                c = crc_shift_in(c, body[k]);
            body[n-2] = c[15:8];
            body[n-1] = c[7:0];
        end
        send_bits(cfg_sync, 32, 1'b0, '0);
        for (int k = 0; k < n; k++)
            send_bits({24'h0, body[k]}, 8, 1'b0, '0);
    endtask

    initial begin : stimulus
        t_stim_row   plan[$];
        t_stim_row   row;
        int          seq;
        int          base_bits;
        int          pick;
        logic [31:0] word;

        // Directed plan. Typed results only where they are obvious: the first
        // byte after reset, and one-byte frames, which can never leave a zero
        // residue from an all-ones start.
        // reset registers: default sync word, first byte is not the last
        plan.push_back(mk_row(ROW_BITS, 1'b0, SYNC_RESET, 32, 1, 1'b0, '0));
        plan.push_back(mk_row(ROW_BITS, 1'b0, 32'h00, 8, 1, 1'b1,
                              t_result'{8'h00, 12'd0, 1'b0, 1'b0}));
        plan.push_back(mk_row(ROW_BITS, 1'b0, 32'hFF, 8, 2, 1'b0, '0));
        // shorten the open frame: the next byte closes it
        plan.push_back(mk_row(ROW_WRITE, REG_FRAME_LENGTH, 32'd4, 0, 0, 1'b0, '0));
        plan.push_back(mk_row(ROW_BITS, 1'b0, 32'h5A, 8, 1, 1'b0, '0));
        // all-ones sync, zero length: frame ends after its first byte
        plan.push_back(mk_row(ROW_WRITE, REG_SYNC_WORD, 32'hFFFF_FFFF, 0, 0, 1'b0, '0));
        plan.push_back(mk_row(ROW_WRITE, REG_FRAME_LENGTH, 32'd0, 0, 0, 1'b0, '0));
        plan.push_back(mk_row(ROW_BITS, 1'b0, 32'hFFFF_FFFF, 32, 1, 1'b0, '0));
        plan.push_back(mk_row(ROW_BITS, 1'b0, 32'h81, 8, 1, 1'b1,
                              t_result'{8'h81, 12'd0, 1'b1, 1'b0}));
        // hunt register kept at all ones: a single 1 bit syncs again
        plan.push_back(mk_row(ROW_WRITE, REG_FRAME_LENGTH, 32'd1, 0, 0, 1'b0, '0));
        plan.push_back(mk_row(ROW_BITS, 1'b0, 32'h1, 1, 1, 1'b0, '0));
        plan.push_back(mk_row(ROW_BITS, 1'b0, 32'h00, 8, 1, 1'b1,
                              t_result'{8'h00, 12'd0, 1'b1, 1'b0}));
        plan.push_back(mk_row(ROW_WRITE, REG_FRAME_LENGTH, 32'd2, 0, 0, 1'b0, '0));
        plan.push_back(mk_row(ROW_BITS, 1'b0, 32'h1, 1, 1, 1'b0, '0));
        plan.push_back(mk_row(ROW_BITS, 1'b0, 32'h7E7E, 16, 1, 1'b0, '0));
        // all-zero sync, shortest regular length
        plan.push_back(mk_row(ROW_WRITE, REG_SYNC_WORD, 32'h0, 0, 0, 1'b0, '0));
        plan.push_back(mk_row(ROW_WRITE, REG_FRAME_LENGTH, 32'd3, 0, 0, 1'b0, '0));
        plan.push_back(mk_row(ROW_BITS, 1'b0, 32'h0, 32, 1, 1'b0, '0));
        plan.push_back(mk_row(ROW_BITS, 1'b0, 32'h12_3456, 24, 1, 1'b0, '0));
        // a length past the cap counts as 4096 and must not end the frame
        // early; close it by a shorter length afterwards
        plan.push_back(mk_row(ROW_WRITE, REG_SYNC_WORD, 32'hA5A5_A5A5, 0, 0, 1'b0, '0));
        plan.push_back(mk_row(ROW_WRITE, REG_FRAME_LENGTH, 32'h1001, 0, 0, 1'b0, '0));
        plan.push_back(mk_row(ROW_BITS, 1'b0, 32'hA5A5_A5A5, 32, 1, 1'b0, '0));
        plan.push_back(mk_row(ROW_BITS, 1'b0, 32'h00, 8, 3, 1'b0, '0));
        plan.push_back(mk_row(ROW_WRITE, REG_FRAME_LENGTH, 32'd4, 0, 0, 1'b0, '0));
        plan.push_back(mk_row(ROW_BITS, 1'b0, 32'hFF, 8, 1, 1'b0, '0));
        // the periodic sync word lets the next hunt hit after 8 bits from
        // the kept register
        plan.push_back(mk_row(ROW_WRITE, REG_FRAME_LENGTH, 32'h1FFF, 0, 0, 1'b0, '0));
        plan.push_back(mk_row(ROW_BITS, 1'b0, 32'hA5, 8, 1, 1'b0, '0));
        plan.push_back(mk_row(ROW_BITS, 1'b0, 32'h3C, 8, 2, 1'b0, '0));
        plan.push_back(mk_row(ROW_WRITE, REG_FRAME_LENGTH, 32'd3, 0, 0, 1'b0, '0));
        plan.push_back(mk_row(ROW_BITS, 1'b0, 32'hC3, 8, 1, 1'b0, '0));

        // hold reset low at the start, then release it once
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < plan.size(); r++) begin
            row = plan[r];
            if (row.kind == ROW_WRITE) begin
                // registers move only with the block idle
                wait_drain();
                apb_write(row.reg_idx, row.value);
            end else begin
                repeat (row.reps)
                    send_bits(row.value, row.nbits, row.typed, row.res);
            end
        end

        // Random part: mostly well-formed frames with random payloads, the
        // rest broken sync words and raw noise.
        base_bits    = bits_sent;
        seq          = 0;
        while (bits_sent - base_bits < 120) begin
            if (seq % 5 == 0) begin
                wait_drain();
                word = $urandom();
                apb_write(REG_SYNC_WORD, word);
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    word = $urandom_range(3, 10);
                else if (pick < 8)
                    word = $urandom_range(0, 2);
                else
                    word = $urandom_range(11, 14);
                apb_write(REG_FRAME_LENGTH, word);
            end
            // stretch with no idling on either side now and then
            calm = ($urandom_range(0, 3) == 0);
            if (seq == 0) begin
                // hold the sink off for a long stretch while bits keep coming,
                // so the output slots fill and the input stalls; then pause
                // until every byte is out
                apb_write(REG_FRAME_LENGTH, 32'd3);
                hold_asks++;
                calm = 1'b1;
                repeat (2) send_frame(1'b1);
                wait_drain();
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    send_frame(pick < 4);
                end else if (pick < 9) begin
                    // sync word with one bit flipped, then a few bytes
                    send_bits(cfg_sync ^ (32'd1 << $urandom_range(0, 31)), 32, 1'b0, '0);
                    repeat ($urandom_range(1, 3))
                        send_bits($urandom_range(0, 255), 8, 1'b0, '0);
                end else begin
                    repeat ($urandom_range(1, 40))
                        send_bit(1'($urandom_range(0, 1)), 1'b0, '0);
                end
            end
            seq++;
        end

        calm = 1'b0;
        wait_drain();
        if (errors_seen == 0)
            $display("sync_hunt_block_deframer_unit_tb: PASS");
        else
            $display("sync_hunt_block_deframer_unit_tb: FAIL");
        $finish;
    end

endmodule
